FILE: src/hst_pkg.sv
// Shared constants and types for the hashed segment table insert block.
package hst_pkg;

  // Default table geometry.
  localparam int unsigned GroupCountDef     = 32;
  localparam int unsigned EntriesPerGroupDef = 8;

  // Word widths and segment number width (256MB segments give the widest number).
  localparam int unsigned WordW = 64;
  localparam int unsigned SegW  = 36;
  localparam int unsigned VsidW = 50;
  localparam int unsigned PsbW  = 9;

  // Segment shifts for the two segment sizes.
  localparam int unsigned Shift256M = 28;
  localparam int unsigned Shift1T   = 40;

  // Entry word constants.
  localparam int unsigned EsidValidBit = 27;
  localparam logic [WordW-1:0] EsidValid = 64'h0000_0000_0800_0000;
  localparam logic [WordW-1:0] VsidFlags = 64'h0000_0000_0000_0C80;

  // Result status codes.
  typedef enum logic [2:0] {
    StPresent  = 3'd0,
    StInserted = 3'd1,
    StFull     = 3'd2,
    StNoVsid   = 3'd3,
    StCleared  = 3'd4
  } status_e;

endpackage

FILE: src/hashed_segment_table_insert.sv
// Top level of the hashed segment table insert and clear block.
//
//   Channel   Direction  Handshake                  Payload
//   command   in         start & !busy              mode, eff_addr, seg_1t, vsid, page_size_bits
//   result    out        valid_o, one cycle strobe  status, group_index, slot_index, in_secondary
//
// An insert runs through the hash, a registered read of the primary row and a registered read
// of the secondary row before its result; when GROUP_COUNT is not a power of two the group
// hash adds the multiply, scale and subtract steps of a reciprocal modulo. A missing VSID is
// answered in the cycle after acceptance, with no table read. A clear sweeps one row per cycle.
// After reset the same sweep runs with busy high. The result strobe
// cannot be held off; the next command is taken while the previous result is on the ports.
module hashed_segment_table_insert import hst_pkg::*; #(
  parameter int unsigned GROUP_COUNT       = GroupCountDef,
  parameter int unsigned ENTRIES_PER_GROUP = EntriesPerGroupDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             mode_i,
  input  logic [WordW-1:0] eff_addr_i,
  input  logic             seg_1t_i,
  input  logic [VsidW-1:0] vsid_i,
  input  logic [PsbW-1:0]  page_size_bits_i,
  output logic             valid_o,
  output logic [2:0]       status_o,
  output logic [4:0]       group_index_o,
  output logic [2:0]       slot_index_o,
  output logic             in_secondary_o
);

  localparam int unsigned GW = $clog2(GROUP_COUNT);
  localparam int unsigned E  = ENTRIES_PER_GROUP;
  localparam int unsigned SW = (E > 1) ? $clog2(E) : 1;
  localparam logic [GW-1:0] LastRow = GW'(GROUP_COUNT - 1);

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SHash  = 5'b00010,
    SCmpP  = 5'b00100,
    SCmpS  = 5'b01000,
    SClear = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [GW-1:0]   clr_cnt_q;
  logic            clr_report_q;
  logic [WordW-1:0] esid_q, vsid_q;
  logic [WordW-1:0] esid_word, vsid_word;
  logic            p_match_q, p_free_q;
  logic [SW-1:0]   p_match_slot_q, p_free_slot_q;

  logic            out_valid_q;
  status_e         status_q;
  logic [4:0]      group_q;
  logic [2:0]      slot_q;
  logic            in_sec_q;

  logic            accept, hash_start, hash_done;
  logic [GW-1:0]   grp_primary, grp_secondary;
  logic [GW-1:0]   rd_addr, wr_addr;
  logic [E-1:0]    wr_en;
  logic [WordW-1:0] esid_wr, vsid_wr;
  logic [E-1:0][WordW-1:0] rd_row;
  logic [E-1:0]    row_match, row_free;
  logic            c_match, c_free;
  logic [SW-1:0]   c_match_slot, c_free_slot;

  // First set bit of a slot vector, lowest slot first.
  function automatic logic [SW:0] first_set(logic [E-1:0] v);
    logic [SW:0] r;
    r = '0;
    for (int i = E - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, SW'(i)};
      end
    end
    return r;
  endfunction

  // Group number masked to the result field width.
  function automatic logic [4:0] grp_field(logic [GW-1:0] g);
    logic [GW+4:0] t;
    t = {5'b0, g};
    return t[4:0];
  endfunction

  // Slot number masked to the result field width.
  function automatic logic [2:0] slot_field(logic [SW-1:0] s);
    logic [SW+2:0] t;
    t = {3'b0, s};
    return t[2:0];
  endfunction

  // One-hot write enable for one slot.
  function automatic logic [E-1:0] slot_onehot(logic [SW-1:0] s);
    logic [E-1:0] r;
    r = '0;
    for (int i = 0; i < E; i++) begin
      if (s == SW'(i)) begin
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  assign busy       = (state_q != SIdle);
  assign accept     = start && !busy;
  assign hash_start = accept && !mode_i && (vsid_i != '0);

  // Entry words of the segment to install.
  assign esid_word = (seg_1t_i ? {eff_addr_i[WordW-1:Shift1T], 40'b0}
                               : {eff_addr_i[WordW-1:Shift256M], 28'b0}) | EsidValid;
  assign vsid_word = (seg_1t_i ? {2'b01, vsid_i[37:0], 24'b0}
                               : {2'b00, vsid_i, 12'b0})
                     | VsidFlags | {{(WordW-PsbW){1'b0}}, page_size_bits_i};

  hst_group_hash #(
    .GROUP_COUNT(GROUP_COUNT)
  ) u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (hash_start),
    .eff_addr_i  (eff_addr_i),
    .seg_1t_i    (seg_1t_i),
    .done_o      (hash_done),
    .primary_o   (grp_primary),
    .secondary_o (grp_secondary)
  );

  hst_table #(
    .GROUP_COUNT      (GROUP_COUNT),
    .ENTRIES_PER_GROUP(ENTRIES_PER_GROUP)
  ) u_table (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_row_o  (rd_row),
    .wr_addr_i (wr_addr),
    .wr_en_i   (wr_en),
    .esid_wr_i (esid_wr),
    .vsid_wr_i (vsid_wr)
  );

  // Match and free flags of the row currently out of the memory.
  always_comb begin
    for (int s = 0; s < E; s++) begin
      row_match[s] = (rd_row[s] == esid_q);
      row_free[s]  = !rd_row[s][EsidValidBit];
    end
    {c_match, c_match_slot} = first_set(row_match);
    {c_free, c_free_slot}   = first_set(row_free);
  end

  // Read the primary row during the hash wait, the secondary right after.
  assign rd_addr = (state_q == SCmpP) ? grp_secondary : grp_primary;

  // Write port: clearing sweep or the single insert at decision time.
  always_comb begin
    wr_addr = grp_primary;
    wr_en   = '0;
    esid_wr = esid_q;
    vsid_wr = vsid_q;
    case (state_q)
      SClear: begin
        wr_addr = clr_cnt_q;
        wr_en   = '1;
        esid_wr = '0;
        vsid_wr = '0;
      end
      SCmpS: begin
        if (!p_match_q && !c_match) begin
          if (p_free_q) begin
            wr_addr = grp_primary;
            wr_en   = slot_onehot(p_free_slot_q);
          end else if (c_free) begin
            wr_addr = grp_secondary;
            wr_en   = slot_onehot(c_free_slot);
          end
        end
      end
      default: begin
        wr_en = '0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (accept) begin
          if (mode_i) begin
            state_d = SClear;
          end else if (vsid_i != '0) begin
            state_d = SHash;
          end
        end
      end
      SHash: begin
        if (hash_done) begin
          state_d = SCmpP;
        end
      end
      SCmpP:  state_d = SCmpS;
      SCmpS:  state_d = SIdle;
      SClear: begin
        if (clr_cnt_q == LastRow) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Control state, sweep counter and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SClear;
      clr_cnt_q    <= '0;
      clr_report_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= 1'b0;
      if (state_q == SClear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastRow) begin
          out_valid_q <= clr_report_q;
        end
      end
      if (accept && mode_i) begin
        clr_cnt_q    <= '0;
        clr_report_q <= 1'b1;
      end
      if (accept && !mode_i && (vsid_i == '0)) begin
        out_valid_q <= 1'b1;
      end
      if (state_q == SCmpS) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Command payload and primary row summary.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      esid_q <= esid_word;
      vsid_q <= vsid_word;
    end
    if (state_q == SCmpP) begin
      p_match_q      <= c_match;
      p_match_slot_q <= c_match_slot;
      p_free_q       <= c_free;
      p_free_slot_q  <= c_free_slot;
    end
  end

  // Result fields.
  always_ff @(posedge clk_i) begin
    if (state_q == SClear && clr_cnt_q == LastRow) begin
      status_q <= StCleared;
      group_q  <= '0;
      slot_q   <= '0;
      in_sec_q <= 1'b0;
    end else if (accept && !mode_i && (vsid_i == '0)) begin
      status_q <= StNoVsid;
      group_q  <= '0;
      slot_q   <= '0;
      in_sec_q <= 1'b0;
    end else if (state_q == SCmpS) begin
      if (p_match_q) begin
        status_q <= StPresent;
        group_q  <= grp_field(grp_primary);
        slot_q   <= slot_field(p_match_slot_q);
        in_sec_q <= 1'b0;
      end else if (c_match) begin
        status_q <= StPresent;
        group_q  <= grp_field(grp_secondary);
        slot_q   <= slot_field(c_match_slot);
        in_sec_q <= 1'b1;
      end else if (p_free_q) begin
        status_q <= StInserted;
        group_q  <= grp_field(grp_primary);
        slot_q   <= slot_field(p_free_slot_q);
        in_sec_q <= 1'b0;
      end else if (c_free) begin
        status_q <= StInserted;
        group_q  <= grp_field(grp_secondary);
        slot_q   <= slot_field(c_free_slot);
        in_sec_q <= 1'b1;
      end else begin
        status_q <= StFull;
        group_q  <= '0;
        slot_q   <= '0;
        in_sec_q <= 1'b0;
      end
    end
  end

  assign valid_o        = out_valid_q;
  assign status_o       = status_q;
  assign group_index_o  = group_q;
  assign slot_index_o   = slot_q;
  assign in_secondary_o = in_sec_q;

endmodule

FILE: src/hst_group_hash.sv
// Primary and secondary group hash of a segment number.
module hst_group_hash import hst_pkg::*; #(
  parameter int unsigned GROUP_COUNT = GroupCountDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [WordW-1:0]               eff_addr_i,
  input  logic                           seg_1t_i,
  output logic                           done_o,
  output logic [$clog2(GROUP_COUNT)-1:0] primary_o,
  output logic [$clog2(GROUP_COUNT)-1:0] secondary_o
);

  localparam int unsigned GW       = $clog2(GROUP_COUNT);
  localparam int unsigned FoldW    = SegW / 2;
  localparam int unsigned NW       = FoldW + GW;
  localparam int unsigned ProdW    = 2 * NW + 1;
  localparam int unsigned RecShift = NW + GW;
  localparam int unsigned QW       = NW + 1 - GW;
  localparam bit IsPow2 = ((GROUP_COUNT & (GROUP_COUNT - 1)) == 0);
  localparam logic [GW:0]   GroupW = (GW + 1)'(GROUP_COUNT);
  // Remainder of the all-ones word, so that the complement hash is a subtraction.
  localparam logic [GW-1:0] CompW  = GW'(64'hFFFF_FFFF_FFFF_FFFF % GROUP_COUNT);
  // Weight of the upper half of the segment number, modulo the group count.
  localparam logic [GW-1:0] FoldK  = GW'((64'd1 << FoldW) % 64'(GROUP_COUNT));
  // Rounded-up reciprocal; exact for every folded value below 2^NW.
  localparam logic [63:0] RecipFull =
      ((64'd1 << RecShift) + 64'(GROUP_COUNT) - 64'd1) / 64'(GROUP_COUNT);
  localparam logic [NW:0]   Recip  = RecipFull[NW:0];
  localparam logic [NW-1:0] GroupN = NW'(GROUP_COUNT);

  // Steps of the modulo, counted down after the fold at start.
  localparam logic [1:0] StepMul   = 2'd3;
  localparam logic [1:0] StepScale = 2'd2;
  localparam logic [1:0] StepSub   = 2'd1;

  logic [SegW-1:0]  sel;
  logic [NW-1:0]    fold, fold_q;
  logic [ProdW-1:0] prod_q;
  logic [QW-1:0]    quot;
  logic [NW-1:0]    quot_g_q, rem_full;
  logic [GW-1:0]    rem_q;
  logic [GW:0]      comp_diff, comp_wrap;
  logic [1:0]       cnt_q;
  logic             done_q;

  // Segment number for the selected segment size.
  assign sel = seg_1t_i ? {12'b0, eff_addr_i[WordW-1:Shift1T]}
                        : eff_addr_i[WordW-1:Shift256M];

  // Fold the upper half onto the lower half; the value keeps its remainder.
  assign fold = NW'(sel[FoldW-1:0]) + NW'(sel[SegW-1:FoldW]) * NW'(FoldK);

  // Quotient by the reciprocal, then the remainder by subtraction.
  assign quot     = prod_q[ProdW-1:RecShift];
  assign rem_full = fold_q - quot_g_q;

  // Step counter and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= IsPow2 ? 2'd0 : StepMul;
      done_q <= IsPow2;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == StepSub) begin
        done_q <= 1'b1;
      end
    end
  end

  // Folded value, product, scaled quotient and remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      fold_q <= fold;
      rem_q  <= IsPow2 ? sel[GW-1:0] : '0;
    end else begin
      case (cnt_q)
        StepMul: begin
          prod_q <= ProdW'(fold_q) * ProdW'(Recip);
        end
        StepScale: begin
          quot_g_q <= NW'(quot) * GroupN;
        end
        StepSub: begin
          rem_q <= rem_full[GW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The complement hash is (all ones mod G) minus the primary, wrapped once.
  assign comp_diff = {1'b0, CompW} - {1'b0, rem_q};
  assign comp_wrap = comp_diff + GroupW;

  assign done_o      = done_q;
  assign primary_o   = rem_q;
  assign secondary_o = (CompW >= rem_q) ? comp_diff[GW-1:0] : comp_wrap[GW-1:0];

endmodule

FILE: src/hst_table.sv
// Segment table storage: one row per group, ESID and VSID words per slot.
module hst_table import hst_pkg::*; #(
  parameter int unsigned GROUP_COUNT       = GroupCountDef,
  parameter int unsigned ENTRIES_PER_GROUP = EntriesPerGroupDef
) (
  input  logic                                     clk_i,
  input  logic [$clog2(GROUP_COUNT)-1:0]           rd_addr_i,
  output logic [ENTRIES_PER_GROUP-1:0][WordW-1:0]  rd_row_o,
  input  logic [$clog2(GROUP_COUNT)-1:0]           wr_addr_i,
  input  logic [ENTRIES_PER_GROUP-1:0]             wr_en_i,
  input  logic [WordW-1:0]                         esid_wr_i,
  input  logic [WordW-1:0]                         vsid_wr_i
);

  logic [ENTRIES_PER_GROUP-1:0][WordW-1:0] esid_mem [GROUP_COUNT];
  logic [ENTRIES_PER_GROUP-1:0][WordW-1:0] vsid_mem [GROUP_COUNT];
  logic [ENTRIES_PER_GROUP-1:0][WordW-1:0] rd_row_q;

  // Slot-enabled writes into the addressed row of both memories.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < ENTRIES_PER_GROUP; s++) begin
      if (wr_en_i[s]) begin
        esid_mem[wr_addr_i][s] <= esid_wr_i;
        vsid_mem[wr_addr_i][s] <= vsid_wr_i;
      end
    end
  end

  // Registered read of one whole ESID row.
  always_ff @(posedge clk_i) begin
    rd_row_q <= esid_mem[rd_addr_i];
  end

  assign rd_row_o = rd_row_q;

endmodule
